// ===== rtl/atrc_pkg.sv =====
// Shared codes, character constants and result type for the AT reply line classifier.
package atrc_pkg;

  // Item operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Result outcome codes
  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_ERR     = 2'd1;
  localparam logic [1:0] OUT_UNKNOWN = 2'd2;
  localparam logic [1:0] OUT_TIMEOUT = 2'd3;

  // Error matcher stages: 0..4 is the matched prefix length of the error tag
  localparam logic [3:0] ST_AFTER = 4'd5;
  localparam logic [3:0] ST_POS   = 4'd6;
  localparam logic [3:0] ST_NEG   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  // Length of the full OK tail "+OK\r\n"
  localparam logic [2:0] OK_FULL = 3'd5;

  // Code magnitude ceiling and the sign flag kept once parsing is over
  localparam logic [16:0] MAG_LIMIT = 17'd32768;
  localparam logic [16:0] SIGN_FLAG = 17'h10000;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_R     = 8'h52;

  // One result transfer
  typedef struct packed {
    logic [1:0]  outcome;
    logic [15:0] code;
  } result_t;

  // Expected character of the OK tail at a given match position
  function automatic logic [7:0] ok_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = CH_PLUS;
      3'd1:    ch = CH_O;
      3'd2:    ch = CH_K;
      3'd3:    ch = CH_CR;
      3'd4:    ch = CH_LF;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Expected character of the error tag "+ERR=" at a given match position
  function automatic logic [7:0] err_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = CH_PLUS;
      4'd1:    ch = CH_E;
      4'd2:    ch = CH_R;
      4'd3:    ch = CH_R;
      4'd4:    ch = CH_EQ;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/atrc_line_parser.sv =====
// Line state registers, streaming matchers and result decision for one accepted item per cycle.
module atrc_line_parser #(
  parameter int LINE_BUFFER_LEN = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        opcode,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       timeout_ticks,
  output logic              res_push,
  output atrc_pkg::result_t res,
  output logic              waiting
);
  import atrc_pkg::*;

  localparam int CNT_W = $clog2(LINE_BUFFER_LEN);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_BUFFER_LEN - 1);

  // State registers
  logic [CNT_W-1:0] byte_count;
  logic             prev_was_cr;
  logic [2:0]       ok_tail_match;
  logic [3:0]       err_match_stage;
  logic [16:0]      code_accumulator;
  logic [15:0]      elapsed_ticks;
  logic [15:0]      last_error;
  logic             nul_seen;

  logic             waiting_next;
  logic [CNT_W-1:0] byte_count_next;
  logic             prev_was_cr_next;
  logic [2:0]       ok_tail_match_next;
  logic [3:0]       err_match_stage_next;
  logic [16:0]      code_accumulator_next;
  logic [15:0]      elapsed_ticks_next;
  logic [15:0]      last_error_next;
  logic             nul_seen_next;

  // Matcher outputs for the current byte
  logic [2:0]  ok_feed;
  logic [3:0]  stage_feed;
  logic [16:0] acc_feed;
  logic        is_digit;
  logic        is_space;
  logic [20:0] acc_x10;
  logic [15:0] code_final;
  logic        code_neg;
  logic [15:0] elapsed_inc;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign acc_x10  = 21'({code_accumulator, 3'b000}) + 21'({code_accumulator, 1'b0})
                  + 21'(rx_byte[3:0]);

  // Advance both pattern matchers and the code parser by one byte
  always_comb begin
    if ((ok_tail_match < OK_FULL) && (rx_byte == ok_char(ok_tail_match))) begin
      ok_feed = ok_tail_match + 3'd1;
    end else begin
      ok_feed = (rx_byte == CH_PLUS) ? 3'd1 : 3'd0;
    end

    stage_feed = err_match_stage;
    acc_feed   = code_accumulator;
    if (err_match_stage < ST_AFTER) begin
      if (rx_byte == err_char(err_match_stage)) begin
        stage_feed = err_match_stage + 4'd1;
      end else begin
        stage_feed = (rx_byte == CH_PLUS) ? 4'd1 : 4'd0;
      end
    end else if (err_match_stage == ST_AFTER) begin
      if (rx_byte == CH_MINUS) begin
        stage_feed = ST_NEG;
      end else if (rx_byte == CH_PLUS) begin
        stage_feed = ST_POS;
      end else if (is_digit) begin
        acc_feed   = 17'(rx_byte[3:0]);
        stage_feed = ST_POS;
      end else if (!is_space) begin
        stage_feed = ST_DONE;
      end
    end else if ((err_match_stage == ST_POS) || (err_match_stage == ST_NEG)) begin
      if (is_digit) begin
        acc_feed = (acc_x10 > 21'(MAG_LIMIT)) ? MAG_LIMIT : acc_x10[16:0];
      end else begin
        if (err_match_stage == ST_NEG) begin
          acc_feed = code_accumulator | SIGN_FLAG;
        end
        stage_feed = ST_DONE;
      end
    end
  end

  // Signed, saturated error code from the updated parser state
  assign code_neg = (stage_feed == ST_NEG) || ((stage_feed == ST_DONE) && acc_feed[16]);
  always_comb begin
    if (code_neg) begin
      code_final = 16'd0 - acc_feed[15:0];
    end else if (acc_feed[15]) begin
      code_final = 16'h7FFF;
    end else begin
      code_final = acc_feed[15:0];
    end
  end

  assign elapsed_inc = (elapsed_ticks != 16'hFFFF) ? (elapsed_ticks + 16'd1) : elapsed_ticks;

  // Next state and result for the accepted item
  always_comb begin
    waiting_next          = waiting;
    byte_count_next       = byte_count;
    prev_was_cr_next      = prev_was_cr;
    ok_tail_match_next    = ok_tail_match;
    err_match_stage_next  = err_match_stage;
    code_accumulator_next = code_accumulator;
    elapsed_ticks_next    = elapsed_ticks;
    last_error_next       = last_error;
    nul_seen_next         = nul_seen;
    res_push              = 1'b0;
    res.outcome           = OUT_UNKNOWN;
    res.code              = last_error;

    if (accept) begin
      unique case (opcode)
        OP_START: begin
          waiting_next          = 1'b1;
          byte_count_next       = '0;
          prev_was_cr_next      = 1'b0;
          ok_tail_match_next    = '0;
          err_match_stage_next  = '0;
          code_accumulator_next = '0;
          elapsed_ticks_next    = '0;
          nul_seen_next         = 1'b0;
        end
        OP_BYTE: begin
          if (waiting && (byte_count < CNT_LIMIT)) begin
            byte_count_next  = byte_count + CNT_W'(1);
            prev_was_cr_next = (rx_byte == CH_CR);
            // Text past a zero byte is not seen by the matchers
            if (!nul_seen) begin
              ok_tail_match_next    = ok_feed;
              err_match_stage_next  = stage_feed;
              code_accumulator_next = acc_feed;
              nul_seen_next         = (rx_byte == CH_NUL);
            end
            if (prev_was_cr && (rx_byte == CH_LF)) begin
              res_push     = 1'b1;
              waiting_next = 1'b0;
              if (ok_tail_match_next == OK_FULL) begin
                res.outcome = OUT_OK;
              end else if (err_match_stage_next >= ST_AFTER) begin
                res.outcome     = OUT_ERR;
                last_error_next = code_final;
                res.code        = code_final;
              end else begin
                res.outcome = OUT_UNKNOWN;
              end
            end
          end
        end
        OP_TICK: begin
          if (waiting) begin
            elapsed_ticks_next = elapsed_inc;
            if (elapsed_inc >= timeout_ticks) begin
              res_push     = 1'b1;
              waiting_next = 1'b0;
              res.outcome  = OUT_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the line state
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting          <= 1'b0;
      byte_count       <= '0;
      prev_was_cr      <= 1'b0;
      ok_tail_match    <= '0;
      err_match_stage  <= '0;
      code_accumulator <= '0;
      elapsed_ticks    <= '0;
      last_error       <= 16'hFFFF;
      nul_seen         <= 1'b0;
    end else begin
      waiting          <= waiting_next;
      byte_count       <= byte_count_next;
      prev_was_cr      <= prev_was_cr_next;
      ok_tail_match    <= ok_tail_match_next;
      err_match_stage  <= err_match_stage_next;
      code_accumulator <= code_accumulator_next;
      elapsed_ticks    <= elapsed_ticks_next;
      last_error       <= last_error_next;
      nul_seen         <= nul_seen_next;
    end
  end

endmodule

// ===== rtl/atrc_out_buf.sv =====
// Two-entry result register with skid slot, so input is taken while a result waits.
module atrc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  atrc_pkg::result_t push_data,
  output logic              full,
  output logic              head_valid,
  output atrc_pkg::result_t head_data,
  input  logic              head_stall
);
  import atrc_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = head_valid && !head_stall;
  assign full = skid_valid;

  // Control: advance the skid into the head on a transfer, park a new result otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head_data <= skid_data;
      end else if (push) begin
        head_data <= push_data;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// ===== rtl/at_response_line_classifier.sv =====
// Top level of the AT reply line classifier: timeout register, parser and result buffer.
//
// Usage:
//   Items arrive on the item channel (item_valid / item_stall) as an opcode and a
//   received byte: start a new wait, one reply byte, or one millisecond tick.
//   A start clears the line state; the first CR LF of the reply then gives one
//   result (OK, error with code, unknown reply), or enough ticks give a timeout.
//   After a result, bytes and ticks are dropped until the next start.
//   Results leave on the result channel (result_valid / result_stall) with the
//   outcome and the last error code (-1 until an error reply has been seen).
//   cfg_write_en / cfg_write_data load the timeout in ticks; write it while idle.
// Timing:
//   One item is taken every cycle while item_stall is low. A result goes straight
//   into the result register when that is empty, else into the skid slot behind it,
//   so input keeps flowing while one result waits; item_stall rises only when both
//   slots hold results, and falls the cycle after the receiver takes one.
// Reset:
//   rst is synchronous. It empties the result slots, ends any wait, restores a
//   timeout of 1000 ticks and sets the last error to -1.
module at_response_line_classifier #(
  parameter int LINE_BUFFER_LEN = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         opcode,
  input  logic [7:0]         rx_byte,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         outcome,
  output logic signed [15:0] error_code,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data
);
  import atrc_pkg::*;

  logic [15:0] timeout_ticks;
  logic        accept;
  logic        res_push;
  result_t     res;
  result_t     head;
  logic        buf_full;
  logic        waiting;
  logic [15:0] u_parser_last_error_view;
  logic [15:0] last_err_shadow;

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 16'd1000;
    end else if (cfg_write_en) begin
      timeout_ticks <= cfg_write_data;
    end
  end

  assign accept     = item_valid && !item_stall;
  assign item_stall = buf_full;

  atrc_line_parser #(
    .LINE_BUFFER_LEN(LINE_BUFFER_LEN)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (opcode),
    .rx_byte      (rx_byte),
    .timeout_ticks(timeout_ticks),
    .res_push     (res_push),
    .res          (res),
    .waiting      (waiting)
  );

  atrc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .full      (buf_full),
    .head_valid(result_valid),
    .head_data (head),
    .head_stall(result_stall)
  );

  assign outcome    = head.outcome;
  assign error_code = signed'(head.code);

  // Shadow of the last error, updated from error results only
  always_ff @(posedge clk) begin
    if (rst) begin
      last_err_shadow <= 16'hFFFF;
    end else if (res_push && (res.outcome == OUT_ERR)) begin
      last_err_shadow <= res.code;
    end
  end
  assign u_parser_last_error_view = last_err_shadow;

  // A full skid slot always sits behind a presented result
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no result presented");

  // Only an accepted byte or tick can produce a result
  a_push_from_item: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (accept && ((opcode == OP_BYTE) || (opcode == OP_TICK))))
    else $error("result produced without a byte or tick transfer");

  // A result ends the wait
  a_push_ends_wait: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !waiting)
    else $error("still waiting after a result");

  // Non-error outcomes carry the kept last error unchanged
  a_code_kept: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res.outcome != OUT_ERR)) |-> (res.code == u_parser_last_error_view))
    else $error("error code changed on a non-error result");

endmodule

// ===== bench/tb_at_response_line_classifier.sv =====
// Testbench for the AT reply line classifier: reply prediction, scoreboard and stimulus.
`timescale 1ns / 1ps

import atrc_pkg::*;

// Predict reply results from accepted items and check them in order
class reply_scoreboard;
  localparam logic [39:0] OK_TAIL  = {CH_PLUS, CH_O, CH_K, CH_CR, CH_LF};
  localparam logic [39:0] ERR_TAG  = {CH_PLUS, CH_E, CH_R, CH_R, CH_EQ};
  localparam int unsigned LINE_LEN = 256;

  logic [15:0] timeout_ticks;
  bit          waiting;
  bit          prev_cr;
  bit          nul_seen;
  int unsigned stored_bytes;
  logic [2:0]  ok_match;
  logic [3:0]  err_stage;
  int unsigned code_mag;
  int unsigned elapsed;
  logic [15:0] last_error;
  result_t     expected_replies[$];
  int unsigned mismatches;
  int unsigned replies_checked;

  function new();
    timeout_ticks   = 16'd1000;
    waiting         = 1'b0;
    last_error      = 16'hFFFF;
    mismatches      = 0;
    replies_checked = 0;
    clear_line();
  endfunction

  function void clear_line();
    stored_bytes = 0;
    prev_cr      = 1'b0;
    ok_match     = 3'd0;
    err_stage    = 4'd0;
    code_mag     = 0;
    elapsed      = 0;
    nul_seen     = 1'b0;
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Signed code from the magnitude and the sign seen so far
  function logic [15:0] parsed_code();
    logic [15:0] m;
    m = code_mag[15:0];
    if (err_stage == ST_NEG || (err_stage == ST_DONE && code_mag[16]))
      return ~m + 16'd1;
    return (code_mag > 32767) ? 16'h7FFF : m;
  endfunction

  // Advance the OK tail matcher and the error tag / code parser by one byte
  function void feed(logic [7:0] c);
    if (ok_match < OK_FULL && c == OK_TAIL[39 - 8 * int'(ok_match) -: 8])
      ok_match++;
    else
      ok_match = (c == CH_PLUS) ? 3'd1 : 3'd0;

    if (err_stage < ST_AFTER) begin
      if (c == ERR_TAG[39 - 8 * int'(err_stage) -: 8])
        err_stage++;
      else
        err_stage = (c == CH_PLUS) ? 4'd1 : 4'd0;
    end else if (err_stage == ST_AFTER) begin
      if (c == CH_MINUS) begin
        err_stage = ST_NEG;
      end else if (c == CH_PLUS) begin
        err_stage = ST_POS;
      end else if (is_digit(c)) begin
        code_mag  = c - CH_ZERO;
        err_stage = ST_POS;
      end else if (!is_blank(c)) begin
        err_stage = ST_DONE;
      end
    end else if (err_stage == ST_POS || err_stage == ST_NEG) begin
      if (is_digit(c)) begin
        code_mag = code_mag * 10 + (c - CH_ZERO);
        if (code_mag > MAG_LIMIT)
          code_mag = 32'(MAG_LIMIT);
      end else begin
        // keep the sign once the digits are over
        if (err_stage == ST_NEG)
          code_mag = code_mag | 32'h10000;
        err_stage = ST_DONE;
      end
    end
  endfunction

  // Take one accepted item; returns 0 when the block ignores it
  function bit take_item(logic [1:0] op, logic [7:0] c);
    result_t r;
    bit      line_end;
    if (op == OP_START) begin
      clear_line();
      waiting = 1'b1;
      return 1'b1;
    end
    if (!waiting || (op != OP_BYTE && op != OP_TICK))
      return 1'b0;

    if (op == OP_TICK) begin
      if (elapsed < 65535)
        elapsed++;
      if (elapsed < timeout_ticks)
        return 1'b1;
      r.outcome = OUT_TIMEOUT;
    end else begin
      // drop bytes beyond the line buffer
      if (stored_bytes >= LINE_LEN - 1)
        return 1'b0;
      stored_bytes++;
      line_end = prev_cr && c == CH_LF;
      prev_cr  = (c == CH_CR);
      if (!nul_seen) begin
        if (c == CH_NUL) begin
          nul_seen = 1'b1;
          ok_match = 3'd0;
          if (err_stage < ST_AFTER)
            err_stage = 4'd0;
          else if (err_stage != ST_DONE)
            feed(CH_NUL);
        end else begin
          feed(c);
        end
      end
      if (!line_end)
        return 1'b1;
      if (ok_match == OK_FULL) begin
        r.outcome = OUT_OK;
      end else if (err_stage >= ST_AFTER) begin
        last_error = parsed_code();
        r.outcome  = OUT_ERR;
      end else begin
        r.outcome = OUT_UNKNOWN;
      end
    end
    waiting = 1'b0;
    r.code  = last_error;
    expected_replies.push_back(r);
    return 1'b1;
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Compare one accepted result with the oldest prediction
  task check_reply(logic [1:0] got_outcome, logic [15:0] got_code);
    result_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("outcome %0d code %0d with no result expected",
                                got_outcome, $signed(got_code)));
      return;
    end
    want = expected_replies.pop_front();
    replies_checked++;
    if (got_outcome !== want.outcome)
      report_mismatch($sformatf("result %0d: outcome %0d, expected %0d",
                                replies_checked, got_outcome, want.outcome));
    if (got_code !== want.code)
      report_mismatch($sformatf("result %0d: error code %0d, expected %0d",
                                replies_checked, $signed(got_code), $signed(want.code)));
  endtask
endclass

module tb_at_response_line_classifier;
  localparam int         LINE_LEN    = 256;
  localparam int         HOLD_CYCLES = 80;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic [1:0]         opcode;
  logic [7:0]         rx_byte;
  logic               result_valid;
  logic               result_stall;
  logic [1:0]         outcome;
  logic signed [15:0] error_code;
  logic               cfg_write_en;
  logic [15:0]        cfg_write_data;

  reply_scoreboard board = new();

  bit          no_idle;
  bit          hold_req;
  bit          count_random;
  int          tick_pct;
  int unsigned taken_items;
  int unsigned random_taken;
  int unsigned settings_written;
  logic [7:0]  line_bytes[$];

  at_response_line_classifier #(
    .LINE_BUFFER_LEN(LINE_LEN)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .opcode        (opcode),
    .rx_byte       (rx_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .outcome       (outcome),
    .error_code    (error_code),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: check each transfer, then pick the next stall
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && !result_stall)
        board.check_reply(outcome, error_code);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !no_idle && ($urandom_range(99) < 12);
      end
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 12) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    rx_byte    <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (board.take_item(op, b)) begin
      taken_items++;
      if (count_random)
        random_taken++;
    end
  endtask

  // Send a byte, with the odd tick or unused opcode slipped in ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (tick_pct > 0 && $urandom_range(99) < tick_pct)
      send_item(OP_TICK, 8'($urandom));
    if ($urandom_range(49) == 0)
      send_item(OP_UNUSED, 8'($urandom));
    send_item(OP_BYTE, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Tick until the wait ends
  task automatic tick_out();
    while (board.waiting) send_item(OP_TICK, 8'($urandom));
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty
  task automatic settle(input int cycles);
    item_valid <= 1'b0;
    while (board.expected_replies.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    settle(6);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en        <= 1'b0;
    board.timeout_ticks = v;
    settings_written++;
  endtask

  // Characters that tend to build partial OK tails and error tags
  function automatic logic [7:0] pick_char();
    case ($urandom_range(11))
      0:       return CH_PLUS;
      1:       return CH_O;
      2:       return CH_K;
      3:       return CH_E;
      4:       return CH_R;
      5:       return CH_EQ;
      6:       return CH_MINUS;
      7:       return 8'($urandom_range(CH_ZERO, CH_NINE));
      8:       return CH_SPACE;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  // One command wait: start, a reply of a random kind, then stray items
  task automatic random_reply();
    int kind;
    int n;
    kind = $urandom_range(9);
    send_item(OP_START, 8'($urandom));
    repeat ($urandom_range(3)) line_bytes.push_back(pick_char());
    case (kind)
      0, 1: begin
        add_text("+OK\r\n");
      end
      2, 3, 4: begin
        add_text("+ERR=");
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            case ($urandom_range(3))
              0:       line_bytes.push_back(CH_SPACE);
              1:       line_bytes.push_back(CH_TAB);
              2:       line_bytes.push_back(8'h0B);
              default: line_bytes.push_back(8'h0C);
            endcase
          end
        end
        case ($urandom_range(3))
          0:       line_bytes.push_back(CH_MINUS);
          1:       line_bytes.push_back(CH_PLUS);
          default: ;
        endcase
        n = ($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
        repeat (n) line_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        repeat ($urandom_range(2)) line_bytes.push_back(pick_char());
        add_text("\r\n");
      end
      5: begin
        repeat ($urandom_range(1, 6)) line_bytes.push_back(pick_char());
        add_text("\r\n");
      end
      6: begin
        repeat ($urandom_range(0, 8)) line_bytes.push_back(8'($urandom));
        add_text("\r\n");
      end
      7: begin
        // zero byte somewhere in an OK or error line
        if ($urandom_range(1))
          add_text("+OK");
        else
          add_text("+ERR=-4");
        line_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        line_bytes.insert($urandom_range(line_bytes.size()), CH_NUL);
        add_text("\r\n");
      end
      8: begin
        // unfinished line, left to time out
        repeat ($urandom_range(0, 5)) line_bytes.push_back(pick_char());
      end
      default: begin
        // restart part way through, then a clean OK
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
        line_bytes.delete();
        send_item(OP_START, 8'($urandom));
        add_text("+OK\r\n");
      end
    endcase
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
    tick_out();
    if ($urandom_range(3) == 0)
      send_item(OP_BYTE, 8'($urandom));
    if ($urandom_range(3) == 0)
      send_item(2'($urandom), 8'($urandom));
  endtask

  // Stimulus
  initial begin : stimulus
    int replies_left;
    logic [15:0] next_timeout;
    no_idle          = 1'b0;
    hold_req         = 1'b0;
    count_random     = 1'b0;
    tick_pct         = 0;
    taken_items      = 0;
    random_taken     = 0;
    settings_written = 0;
    rst            <= 1'b1;
    item_valid     <= 1'b0;
    opcode         <= OP_START;
    rx_byte        <= 8'h00;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 16'h0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Items before any start are dropped
    send_item(OP_BYTE, CH_PLUS);
    send_item(OP_TICK, 8'h00);
    send_item(OP_UNUSED, 8'hFF);

    // OK, saturated codes of both signs, empty code, zero byte
    send_item(OP_START, 8'h00);
    send_text("+OK\r\n");
    send_item(OP_START, 8'hFF);
    send_text("+ERR=");
    send_item(OP_UNUSED, 8'h00);
    send_text("-99999\r\n");
    send_item(OP_START, 8'h00);
    send_text("AT+ERR= +70000\r\n");
    send_item(OP_START, 8'h00);
    send_text("+ERR=\r\n");
    send_item(OP_START, 8'h00);
    send_text("+O");
    send_item(OP_BYTE, CH_NUL);
    send_text("K\r\n");

    // Restart while waiting; bytes after the result are dropped
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_START, 8'h00);
    send_text("+OK\r\nx\r\n");

    // No early timeout at the reset setting
    send_item(OP_START, 8'h00);
    repeat (40) send_item(OP_TICK, 8'h00);
    send_text("+OK\r\n");

    // Zero timeout behaves as one
    write_timeout(16'd0);
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'h00);

    // Receiver holds off while results pile up behind it
    write_timeout(16'd1);
    hold_req = 1'b1;
    repeat (24) begin
      send_item(OP_START, 8'($urandom));
      send_item(OP_TICK, 8'($urandom));
    end

    // Line that just fits, then one whose LF falls beyond the buffer
    write_timeout(16'd3);
    send_item(OP_START, 8'h00);
    repeat (LINE_LEN - 3) send_item(OP_BYTE, CH_E);
    send_text("\r\n");
    send_item(OP_START, 8'h00);
    repeat (LINE_LEN - 2) send_item(OP_BYTE, CH_E);
    send_text("\r\n");
    tick_out();

    // Random replies in phases of varying timeout and tick density
    count_random = 1'b1;
    replies_left = 0;
    while (random_taken < 400) begin
      if (replies_left == 0) begin
        case ($urandom_range(2))
          0:       next_timeout = 16'd1;
          1:       next_timeout = 16'($urandom_range(2, 6));
          default: next_timeout = 16'($urandom_range(7, 40));
        endcase
        write_timeout(next_timeout);
        case ($urandom_range(2))
          0:       tick_pct = 0;
          1:       tick_pct = 4;
          default: tick_pct = 10;
        endcase
        no_idle      = (settings_written == 5);
        replies_left = $urandom_range(8, 20);
      end
      random_reply();
      replies_left--;
    end
    count_random = 1'b0;
    no_idle      = 1'b0;
    tick_pct     = 0;

    // Largest timeout: ticks do not end the wait early
    write_timeout(16'hFFFF);
    no_idle = 1'b1;
    send_item(OP_START, 8'h00);
    repeat (40) send_item(OP_TICK, 8'h00);
    send_text("+OK\r\n");
    no_idle = 1'b0;

    settle(20);
    $display("Covered %0d accepted items, %0d of them in random replies, %0d results checked",
             taken_items, random_taken, board.replies_checked);
    $display("across %0d timeout settings from 0 to 65535, with stalls and a long hold-off.",
             settings_written);
    if (board.mismatches == 0 && board.expected_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/atrc_pkg.sv
rtl/atrc_line_parser.sv
rtl/atrc_out_buf.sv
rtl/at_response_line_classifier.sv
bench/tb_at_response_line_classifier.sv
